/* design/dhoat_pkg.sv */
// shared types and constants for the double-hashing open-address table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dhoat_pkg;

    localparam int unsigned SLOTS       = 256;
    localparam int unsigned SLOT_W      = $clog2(SLOTS);
    localparam int unsigned KEY_W       = 31;
    localparam int unsigned VAL_W       = 32;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - VAL_W - COUNT_W;

    localparam logic [31:0] HOME_MUL = 32'd2654435766;
    localparam logic [31:0] STEP_MUL = 32'd3037000499;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]       mark;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_row;

    typedef struct packed {
        logic       load_item;
        logic       calc_home;
        logic       calc_step;
        logic       rd_next;
        logic       ins_write;
        logic       tomb_write;
        logic       advance;
        logic       set_result;
        logic [1:0] res_status;
        logic       res_take_value;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       below_limit;
        logic [1:0] mark;
        logic       key_match;
        logic       last_probe;
        logic       out_free;
    } t_dp_stat;

endpackage

/* design/double_hash_open_address_table.sv */
// top level of the double-hashing open-address table
// depends on dhoat_pkg, dhoat_ctrl and dhoat_datapath
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/tready         tuser command, tdata key/value_in
//   m_axis    out        m_axis_tvalid/tready         tuser status, tdata value_out/live_count
//   cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_data live_limit
//
// one word at a time: hashing computes the home slot and then the step on a shared
// multiplier, then the table probes slot after slot (one memory read port), then
// the output register is loaded; a new word is accepted only after that load
// an insert at the limit or an undefined command skips probing
// synchronous reset marks every slot empty at once through per-slot valid bits
// a waiting result holds the next word in the finish step until the output drains
`timescale 1ns / 1ps

module double_hash_open_address_table (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [dhoat_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // key, value_in
    input  logic [1:0]                            s_axis_tuser,  // command
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [dhoat_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // value_out, live_count
    output logic [1:0]                            m_axis_tuser,  // status
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dhoat_pkg::COUNT_W-1:0]         i_cfg_data
);
    import dhoat_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    dhoat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    dhoat_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_write (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

/* design/dhoat_ctrl.sv */
// controller state machine: sequences hashing, probing and result hand-off
// depends on dhoat_pkg; drives the datapath through t_dp_cmd
`timescale 1ns / 1ps

module dhoat_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dhoat_pkg::t_dp_stat i_stat,
    output dhoat_pkg::t_dp_cmd  o_cmd
);
    import dhoat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOME,
        S_STEP,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_HOME;
                end
            end
            S_HOME: begin
                cmd.calc_home = 1'b1;
                if (i_stat.op == CMD_FIND || i_stat.op == CMD_REMOVE ||
                    (i_stat.op == CMD_INSERT && i_stat.below_limit)) begin
                    n_state = S_STEP;
                end else begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_FINISH;
                end
            end
            S_STEP: begin
                cmd.calc_step = 1'b1;
                n_state       = S_PROBE;
            end
            S_PROBE: begin
                cmd.rd_next = 1'b1;
                if (i_stat.op == CMD_INSERT) begin
                    if (i_stat.mark != MARK_USED) begin
                        cmd.ins_write  = 1'b1;
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_DONE;
                        n_state        = S_FINISH;
                    end else if (i_stat.key_match) begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_DUP;
                        n_state        = S_FINISH;
                    end else if (i_stat.last_probe) begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_FULL;
                        n_state        = S_FINISH;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end else begin
                    if (i_stat.mark == MARK_EMPTY) begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_MISS;
                        n_state        = S_FINISH;
                    end else if (i_stat.mark == MARK_USED && i_stat.key_match) begin
                        cmd.set_result     = 1'b1;
                        cmd.res_status     = ST_DONE;
                        cmd.res_take_value = 1'b1;
                        cmd.tomb_write     = (i_stat.op == CMD_REMOVE);
                        n_state            = S_FINISH;
                    end else if (i_stat.last_probe) begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_FULL;
                        n_state        = S_FINISH;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/dhoat_datapath.sv */
// datapath: item registers, hash multiplier, slot memory, counters, output word
// depends on dhoat_pkg; commanded by dhoat_ctrl
`timescale 1ns / 1ps

module dhoat_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dhoat_pkg::t_dp_cmd                     i_cmd,
    output dhoat_pkg::t_dp_stat                    o_stat,
    input  logic [dhoat_pkg::IN_TDATA_W-1:0]       i_in_data,
    input  logic [1:0]                             i_in_user,
    input  logic                                   i_cfg_write,
    input  logic [dhoat_pkg::COUNT_W-1:0]          i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [dhoat_pkg::OUT_TDATA_W-1:0]      o_out_data,
    output logic [1:0]                             o_out_user
);
    import dhoat_pkg::*;

    logic [1:0]         r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [SLOT_W-1:0]  r_h;
    logic [SLOT_W-1:0]  r_step;
    logic [SLOT_W-1:0]  r_probe;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_limit;
    logic [1:0]         r_res_status;
    logic [VAL_W-1:0]   r_res_value;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [VAL_W-1:0]   r_out_value;
    logic [COUNT_W-1:0] r_out_count;

    t_row               r_mem [SLOTS];
    logic [SLOTS-1:0]   r_slot_valid;
    t_row               r_rd_row;
    logic               r_rd_hit;

    logic [31:0]        mul_const;
    logic [31:0]        hash_frac;
    logic [SLOT_W-1:0]  hash_slot;
    logic [SLOT_W-1:0]  next_h;
    logic [SLOT_W-1:0]  rd_addr;
    logic [1:0]         rd_mark;
    t_row               wr_row;
    logic               wr_en;

    // shared multiplier, low 32 bits of key times the home or step constant
    assign mul_const = i_cmd.calc_step ? STEP_MUL : HOME_MUL;
    assign hash_frac = 32'({1'b0, r_key} * mul_const);
    assign hash_slot = hash_frac[31 -: SLOT_W];

    assign next_h  = r_h + r_step;
    assign rd_addr = i_cmd.rd_next ? next_h : r_h;
    assign rd_mark = r_rd_hit ? r_rd_row.mark : MARK_EMPTY;

    assign wr_en        = i_cmd.ins_write | i_cmd.tomb_write;
    assign wr_row.mark  = i_cmd.ins_write ? MARK_USED : MARK_TOMB;
    assign wr_row.key   = r_key;
    assign wr_row.value = i_cmd.ins_write ? r_val : r_rd_row.value;

    assign o_stat.op          = r_op;
    assign o_stat.below_limit = (r_count < r_limit);
    assign o_stat.mark        = rd_mark;
    assign o_stat.key_match   = (r_rd_row.key == r_key);
    assign o_stat.last_probe  = (r_probe == SLOT_W'(SLOTS - 1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_status;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_value};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_h] <= wr_row;
        end
        r_rd_row <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_rd_hit     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_slot_valid[r_h] <= 1'b1;
            end
            r_rd_hit <= r_slot_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= CMD_INSERT;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.load_item) begin
                r_op <= i_in_user;
            end
            if (i_cmd.ins_write) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.tomb_write && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_key <= i_in_data[KEY_W-1:0];
            r_val <= i_in_data[KEY_W +: VAL_W];
        end
        if (i_cmd.calc_home) begin
            r_h <= hash_slot;
        end
        if (i_cmd.calc_step) begin
            r_step  <= hash_slot | SLOT_W'(1);
            r_probe <= '0;
        end
        if (i_cmd.advance) begin
            r_h     <= next_h;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= i_cmd.res_take_value ? r_rd_row.value : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_count  <= r_count;
        end
    end

endmodule

/* design/dhoat_checker.sv */
// port-level checks on the double-hashing open-address table
// depends on dhoat_pkg; bound to double_hash_open_address_table
`timescale 1ns / 1ps

module dhoat_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [dhoat_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic [1:0]                            m_axis_tuser
);
    import dhoat_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // value only on a done status
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata[VAL_W-1:0] == '0)
        else $error("nonzero value on a failed operation");

    // live count never exceeds the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[VAL_W +: COUNT_W] <= COUNT_W'(SLOTS))
        else $error("live count above slot count");

    // no input taken in the cycle after one was accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while busy");

endmodule

bind double_hash_open_address_table dhoat_checker u_dhoat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
